@@ rtl/imm_pkg.sv @@
package imm_pkg;

   localparam int MAX_DIM_DEFAULT    = 64;
   localparam int ELEM_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 4;

   localparam int SIZE_W      = 7;
   localparam int IDX_W       = 6;
   localparam int PROD_W      = 38;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // request action codes
   localparam logic [1:0] ACT_WRITE_A = 2'd0;
   localparam logic [1:0] ACT_WRITE_B = 2'd1;
   localparam logic [1:0] ACT_QUERY   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_B    = 2'd2;

   typedef enum logic [1:0] {
      KIND_WRITE_A,
      KIND_WRITE_B,
      KIND_QUERY,
      KIND_QUERY_ERR
   } imm_kind_type;

   typedef struct packed {
      imm_kind_type      kind;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [SIZE_W-1:0] inner;
   } imm_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } imm_state_type;

endpackage

@@ rtl/imm_front.sv @@
module imm_front #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [imm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [imm_pkg::SIZE_W-1:0]        csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [imm_pkg::IDX_W-1:0]         req_row_index,
   input  logic [imm_pkg::IDX_W-1:0]         req_col_index,
   input  logic                              q_full,
   output logic                              q_push,
   output imm_pkg::imm_cmd_type              q_cmd
);

   localparam int SIZE_MAX = (1 << imm_pkg::SIZE_W) - 1;
   localparam int CAP_SIZE = (MAX_DIM > SIZE_MAX) ? SIZE_MAX : MAX_DIM;
   localparam logic [imm_pkg::SIZE_W-1:0] CAP = imm_pkg::SIZE_W'(CAP_SIZE);

   logic [imm_pkg::SIZE_W-1:0] rows_a_ff, rows_a_in;
   logic [imm_pkg::SIZE_W-1:0] inner_dim_ff, inner_dim_in;
   logic [imm_pkg::SIZE_W-1:0] cols_b_ff, cols_b_in;

   logic [imm_pkg::SIZE_W-1:0] nr, nk, nc;
   logic [imm_pkg::SIZE_W-1:0] row_ext, col_ext;
   logic                       keep;

   assign csr_ready = 1'b1;

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_b_in    = cols_b_ff;
      if (csr_valid) begin
         unique case (csr_index)
            imm_pkg::CSR_ROWS_A:    rows_a_in    = csr_data;
            imm_pkg::CSR_INNER_DIM: inner_dim_in = csr_data;
            imm_pkg::CSR_COLS_B:    cols_b_in    = csr_data;
            default:                rows_a_in    = rows_a_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= imm_pkg::SIZE_RESET;
         inner_dim_ff <= imm_pkg::SIZE_RESET;
         cols_b_ff    <= imm_pkg::SIZE_RESET;
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   // clamp sizes to the store dimension
   assign nr = (rows_a_ff > CAP) ? CAP : rows_a_ff;
   assign nk = (inner_dim_ff > CAP) ? CAP : inner_dim_ff;
   assign nc = (cols_b_ff > CAP) ? CAP : cols_b_ff;

   assign row_ext = imm_pkg::SIZE_W'(req_row_index);
   assign col_ext = imm_pkg::SIZE_W'(req_col_index);

   always_comb begin
      q_cmd.row   = req_row_index;
      q_cmd.col   = req_col_index;
      q_cmd.inner = nk;
      q_cmd.kind  = imm_pkg::KIND_QUERY_ERR;
      keep        = 1'b0;
      unique case (req_action)
         imm_pkg::ACT_WRITE_A: begin
            q_cmd.kind = imm_pkg::KIND_WRITE_A;
            keep       = (row_ext < nr) && (col_ext < nk);
         end
         imm_pkg::ACT_WRITE_B: begin
            q_cmd.kind = imm_pkg::KIND_WRITE_B;
            keep       = (row_ext < nk) && (col_ext < nc);
         end
         imm_pkg::ACT_QUERY: begin
            keep = 1'b1;
            if ((row_ext < nr) && (col_ext < nc)) begin
               q_cmd.kind = imm_pkg::KIND_QUERY;
            end else begin
               q_cmd.kind = imm_pkg::KIND_QUERY_ERR;
            end
         end
         default: keep = 1'b0;
      endcase
   end

   // drop ignored writes and unused actions at the door
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && keep;

endmodule

@@ rtl/imm_queue.sv @@
module imm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = imm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/imm_back.sv @@
module imm_back #(
   parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  imm_pkg::imm_cmd_type                q_cmd,
   input  logic [ELEM_WIDTH-1:0]               q_elem,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [imm_pkg::PROD_W-1:0]   rsp_product_value,
   output logic                                rsp_status
);

   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int AW        = $clog2(DEPTH);
   localparam int KW        = $clog2(MAX_DIM);
   localparam int PRODUCT_W = 2 * ELEM_WIDTH;
   localparam logic [AW-1:0] STRIDE = AW'(MAX_DIM);

   logic [ELEM_WIDTH-1:0] mem_a_ff [DEPTH];
   logic [ELEM_WIDTH-1:0] mem_b_ff [DEPTH];

   imm_pkg::imm_state_type state_ff, state_in;

   logic [imm_pkg::IDX_W-1:0] row_ff, row_in;
   logic [imm_pkg::IDX_W-1:0] col_ff, col_in;
   logic [KW-1:0]             k_ff, k_in;
   logic [KW-1:0]             last_ff, last_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic                      mul_vld_ff, mul_vld_in;
   logic signed [ELEM_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic signed [PRODUCT_W-1:0]  prod_ff, prod_in;
   logic [imm_pkg::PROD_W-1:0]   acc_ff, acc_in;
   logic [imm_pkg::PROD_W-1:0]   term;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [imm_pkg::PROD_W-1:0] rsp_value_ff, rsp_value_in;
   logic                       rsp_status_ff, rsp_status_in;

   logic          rsp_free, head_write;
   logic          wr_a, wr_b, start, err_done, issue, done;
   logic [AW-1:0] w_addr, a_addr, b_addr;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign head_write = (q_cmd.kind == imm_pkg::KIND_WRITE_A) ||
                       (q_cmd.kind == imm_pkg::KIND_WRITE_B);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imm_pkg::ST_IDLE: begin
            if (q_pop && (q_cmd.kind == imm_pkg::KIND_QUERY)) begin
               state_in = (q_cmd.inner == '0) ? imm_pkg::ST_DRAIN : imm_pkg::ST_RUN;
            end
         end
         imm_pkg::ST_RUN: begin
            if (k_ff == last_ff) begin
               state_in = imm_pkg::ST_DRAIN;
            end
         end
         imm_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = imm_pkg::ST_IDLE;
            end
         end
         default: state_in = imm_pkg::ST_IDLE;
      endcase
   end

   // controls
   always_comb begin
      q_pop    = 1'b0;
      wr_a     = 1'b0;
      wr_b     = 1'b0;
      start    = 1'b0;
      err_done = 1'b0;
      issue    = 1'b0;
      done     = 1'b0;
      unique case (state_ff)
         imm_pkg::ST_IDLE: begin
            q_pop    = q_valid && (rsp_free || head_write);
            wr_a     = q_pop && (q_cmd.kind == imm_pkg::KIND_WRITE_A);
            wr_b     = q_pop && (q_cmd.kind == imm_pkg::KIND_WRITE_B);
            start    = q_pop && (q_cmd.kind == imm_pkg::KIND_QUERY);
            err_done = q_pop && (q_cmd.kind == imm_pkg::KIND_QUERY_ERR);
         end
         imm_pkg::ST_RUN:   issue = 1'b1;
         imm_pkg::ST_DRAIN: done  = !rd_vld_ff && !mul_vld_ff;
         default:           issue = 1'b0;
      endcase
   end

   assign w_addr = AW'(q_cmd.row) * STRIDE + AW'(q_cmd.col);
   assign a_addr = AW'(row_ff) * STRIDE + AW'(k_ff);
   assign b_addr = AW'(k_ff) * STRIDE + AW'(col_ff);

   assign prod_in = rd_a_ff * rd_b_ff;
   assign term    = imm_pkg::PROD_W'(prod_ff);

   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      k_in       = k_ff;
      last_in    = last_ff;
      acc_in     = acc_ff;
      rd_vld_in  = issue;
      mul_vld_in = rd_vld_ff;
      if (start) begin
         row_in  = q_cmd.row;
         col_in  = q_cmd.col;
         k_in    = '0;
         last_in = KW'(q_cmd.inner - 1'b1);
         acc_in  = '0;
      end else begin
         if (issue) begin
            k_in = k_ff + 1'b1;
         end
         if (mul_vld_ff) begin
            acc_in = acc_ff + term;
         end
      end
   end

   // hold the result until the consumer takes it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (err_done) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = 1'b1;
      end else if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = acc_ff;
         rsp_status_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imm_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= mul_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      k_ff          <= k_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a_ff[w_addr] <= q_elem;
      end
      rd_a_ff <= mem_a_ff[a_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b_ff[w_addr] <= q_elem;
      end
      rd_b_ff <= mem_b_ff[b_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;

   a_busy_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff != imm_pkg::ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while a query runs");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_value_ff == '0))
      else $error("error result carries nonzero value");

   a_pipe_follow: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |=> mul_vld_ff)
      else $error("read data lost before multiply");

   a_run_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == imm_pkg::ST_RUN) |=>
      ((state_ff == imm_pkg::ST_RUN) || (state_ff == imm_pkg::ST_DRAIN)))
      else $error("run state left without drain");

endmodule

@@ rtl/integer_matrix_multiply.sv @@
// Transactions enter the queue at one per cycle unless req_stall (queue full) holds them.
// Writes of A or B elements reach the store when the execution side pops them while idle.
// A query holds the execution side (one multiply-accumulate per cycle through the store
// read ports) until its result is in the result register, so no request is popped
// meanwhile; inner_dim 0 skips the run. Out-of-range queries answer when popped.
// Reset sets all three sizes to 64 and empties the queue and result register; the element
// stores are not cleared and no sweep is run.
module integer_matrix_multiply #(
   parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [imm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [imm_pkg::SIZE_W-1:0]        csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [imm_pkg::IDX_W-1:0]         req_row_index,
   input  logic [imm_pkg::IDX_W-1:0]         req_col_index,
   input  logic signed [ELEM_WIDTH-1:0]      req_element_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [imm_pkg::PROD_W-1:0] rsp_product_value,
   output logic [0:0]                        rsp_status
);

   localparam int CMD_W = $bits(imm_pkg::imm_cmd_type);
   localparam int Q_W   = CMD_W + ELEM_WIDTH;

   imm_pkg::imm_cmd_type  push_cmd, head_cmd;
   logic                  push, full, pop, head_valid;
   logic [Q_W-1:0]        push_data, head_data;
   logic [ELEM_WIDTH-1:0] head_elem;

   imm_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .q_full        (full),
      .q_push        (push),
      .q_cmd         (push_cmd)
   );

   assign push_data = {push_cmd, req_element_value};

   imm_queue #(
      .WIDTH (Q_W),
      .DEPTH (imm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (head_valid),
      .pop_data  (head_data)
   );

   assign head_cmd  = imm_pkg::imm_cmd_type'(head_data[Q_W-1:ELEM_WIDTH]);
   assign head_elem = head_data[ELEM_WIDTH-1:0];

   imm_back #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (head_valid),
      .q_cmd             (head_cmd),
      .q_elem            (head_elem),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_value (rsp_product_value),
      .rsp_status        (rsp_status[0])
   );

endmodule
